FILE: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and codes of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned BbW   = 17;
	localparam int unsigned TotW  = 11;

	// configuration register indexes
	localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
	localparam logic [1:0] REG_BLOCK_BYTES  = 2'd1;
	localparam logic [1:0] REG_TOTAL_BLOCKS = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOROOM  = 2'd1;
	localparam logic [1:0] ST_BADADDR = 2'd2;

	// mark table bits
	localparam logic [2:0] MARK_USED  = 3'b001;
	localparam logic [2:0] MARK_START = 3'b010;
	localparam logic [2:0] MARK_END   = 3'b100;

	// job kinds handed from the front to the back
	typedef enum logic [1:0] {
		K_ALLOC   = 2'd0,
		K_REJECT  = 2'd1,
		K_FREE    = 2'd2,
		K_BADADDR = 2'd3
	} kind_t;

	typedef struct packed {
		logic [DataW-1:0] heap_base;
		logic [BbW-1:0]   bb_eff;
	} heap_cfg_t;

endpackage

FILE: rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int unsigned WIDTH = 3,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/ffba_queue.sv
// ----------------------------------------------------------------------------
// ffba_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ffba_queue #(
	parameter int unsigned W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] ent_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: rtl/ffba_front.sv
// ----------------------------------------------------------------------------
// ffba_front
// accepts requests, divides by the block size and classifies the job
// ----------------------------------------------------------------------------
module ffba_front #(
	parameter int unsigned CW = 11
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     enable,
	input  ffba_pkg::heap_cfg_t      cfg,
	input  logic [CW-1:0]            eff_total,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_cmd,
	input  logic [31:0]              in_size,
	input  logic [31:0]              in_addr,
	output logic                     job_valid,
	input  logic                     job_ready,
	output ffba_pkg::kind_t          job_kind,
	output logic [CW-1:0]            job_val
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t     state_q;
	logic        cmd_q;
	logic [31:0] dq_q;
	logic [17:0] rem_q;
	logic [4:0]  cnt_q;
	logic [17:0] rem_sh;
	logic        fits;
	logic [32:0] need;

	assign in_ready = (state_q == F_IDLE) && enable;
	assign rem_sh   = {rem_q[16:0], dq_q[31]};
	assign fits     = (rem_sh >= {1'b0, cfg.bb_eff});
	assign need     = {1'b0, dq_q} + {32'd0, (rem_q != 18'd0)};

	always_comb begin
		job_valid = (state_q == F_PUSH);
		job_val   = '0;
		if (cmd_q) begin
			if ({1'b0, dq_q} >= 33'(eff_total)) begin
				job_kind = ffba_pkg::K_BADADDR;
			end else begin
				job_kind = ffba_pkg::K_FREE;
				job_val  = dq_q[CW-1:0];
			end
		end else begin
			if (need == 33'd0 || need >= 33'(eff_total)) begin
				job_kind = ffba_pkg::K_REJECT;
			end else begin
				job_kind = ffba_pkg::K_ALLOC;
				job_val  = need[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				cmd_q <= in_cmd;
				dq_q  <= in_cmd ? (in_addr - cfg.heap_base) : in_size;
				rem_q <= '0;
			end
			F_DIV: begin
				dq_q  <= {dq_q[30:0], fits};
				rem_q <= fits ? (rem_sh - {1'b0, cfg.bb_eff}) : rem_sh;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid && in_ready) begin
						cnt_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (job_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/ffba_back.sv
// ----------------------------------------------------------------------------
// ffba_back
// carries out jobs on the block mark table and drives the result register
// ----------------------------------------------------------------------------
module ffba_back #(
	parameter int unsigned MAX_BLOCKS = 1024,
	parameter int unsigned IW = 10,
	parameter int unsigned CW = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffba_pkg::heap_cfg_t cfg,
	input  logic [CW-1:0]       eff_total,
	output logic                init_done,
	input  logic                job_valid,
	output logic                job_ready,
	input  ffba_pkg::kind_t     job_kind,
	input  logic [CW-1:0]       job_val,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_status,
	output logic [31:0]         out_addr
);

	typedef enum logic [11:0] {
		B_CLR  = 12'b000000000001,
		B_IDLE = 12'b000000000010,
		B_ARD  = 12'b000000000100,
		B_ACHK = 12'b000000001000,
		B_AWR  = 12'b000000010000,
		B_MUL  = 12'b000000100000,
		B_ADD  = 12'b000001000000,
		B_FRD  = 12'b000010000000,
		B_FCHK = 12'b000100000000,
		B_CRD  = 12'b001000000000,
		B_CCHK = 12'b010000000000,
		B_RES  = 12'b100000000000
	} bstate_t;

	localparam int unsigned PW = ffba_pkg::BbW + IW;

	bstate_t       state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] need_q;
	logic [CW-1:0] start_q;
	logic [CW-1:0] end_q;
	logic [PW-1:0] prod_q;
	logic [1:0]    res_status_q;
	logic [31:0]   res_addr_q;
	logic          out_valid_q;

	logic          we;
	logic [IW-1:0] waddr;
	logic [2:0]    wdata;
	logic [IW-1:0] raddr;
	logic [2:0]    rdata;

	ffba_ram #(.WIDTH(3), .DEPTH(MAX_BLOCKS)) u_marks (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign init_done  = (state_q != B_CLR);
	assign job_ready  = (state_q == B_IDLE);
	assign out_valid  = out_valid_q;
	assign raddr      = idx_q[IW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[IW-1:0];
		wdata = 3'b000;
		case (state_q)
			B_CLR: we = 1'b1;
			B_AWR: begin
				we    = 1'b1;
				wdata = ffba_pkg::MARK_USED
					| ((idx_q == start_q) ? ffba_pkg::MARK_START : 3'b000)
					| ((idx_q == end_q) ? ffba_pkg::MARK_END : 3'b000);
			end
			B_CCHK: we = 1'b1;
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				res_addr_q   <= '0;
				res_status_q <= (job_kind == ffba_pkg::K_BADADDR) ?
					ffba_pkg::ST_BADADDR : ffba_pkg::ST_NOROOM;
				need_q       <= job_val;
				run_q        <= '0;
			end
			B_ACHK: begin
				if (rdata[0]) begin
					run_q <= '0;
				end else begin
					run_q <= run_q + 1'b1;
					if (run_q + 1'b1 == need_q) begin
						start_q <= idx_q - need_q + 1'b1;
						end_q   <= idx_q;
					end
				end
			end
			B_MUL: prod_q <= PW'(cfg.bb_eff) * PW'(start_q[IW-1:0]);
			B_ADD: begin
				res_addr_q   <= cfg.heap_base + 32'(prod_q);
				res_status_q <= ffba_pkg::ST_DONE;
			end
			B_FCHK: begin
				if (rdata[1]) res_status_q <= ffba_pkg::ST_DONE;
				else res_status_q <= ffba_pkg::ST_BADADDR;
			end
			default: ;
		endcase
		if (state_q == B_RES && (!out_valid_q || out_ready)) begin
			out_status <= res_status_q;
			out_addr   <= res_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_RES && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				B_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CW'(MAX_BLOCKS - 1)) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (job_valid) begin
						case (job_kind)
							ffba_pkg::K_ALLOC: begin
								idx_q   <= '0;
								state_q <= B_ARD;
							end
							ffba_pkg::K_FREE: begin
								idx_q   <= job_val;
								state_q <= B_FRD;
							end
							default: state_q <= B_RES;
						endcase
					end
				end
				B_ARD: begin
					// end of a fitting run must stay below the heap size
					if (idx_q >= eff_total) state_q <= B_RES;
					else state_q <= B_ACHK;
				end
				B_ACHK: begin
					if (!rdata[0] && (run_q + 1'b1 == need_q)) begin
						idx_q   <= idx_q - need_q + 1'b1;
						state_q <= B_AWR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_ARD;
					end
				end
				B_AWR: begin
					if (idx_q == end_q) state_q <= B_MUL;
					else idx_q <= idx_q + 1'b1;
				end
				B_MUL: state_q <= B_ADD;
				B_ADD: state_q <= B_RES;
				B_FRD: state_q <= B_FCHK;
				B_FCHK: begin
					if (rdata[1]) begin
						state_q <= B_CRD;
					end else if (idx_q == '0) begin
						state_q <= B_RES;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= B_FRD;
					end
				end
				B_CRD: begin
					if (idx_q >= eff_total) state_q <= B_RES;
					else state_q <= B_CCHK;
				end
				B_CCHK: begin
					if (rdata[2]) begin
						state_q <= B_RES;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_CRD;
					end
				end
				B_RES: begin
					if (!out_valid_q || out_ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator of contiguous block runs over a mark table
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser cmd, tdata size_bytes, addr
// m_*       out  m_tvalid/m_tready   tdata status, addr_out
// cfg_*     in   cfg_we              cfg_index, cfg_data
//
// front: accepts a request, runs a bit-serial divide, then hands the job over.
// back: alloc scans and checks blocks, marks the found run and forms its address;
// free walks back to the start mark and clears through the end mark, then reports.
// after reset a clearing pass over all MAX_BLOCKS entries runs before s_tready rises.
// a two-entry queue between front and back, and the result register, absorb stalls.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
	parameter int unsigned MAX_BLOCKS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,    // cmd
	input  logic [63:0] s_tdata,    // size_bytes[31:0], addr[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // status[1:0], addr_out[33:2], zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = IW + 1;
	localparam int unsigned QW = 2 + CW;

	logic [31:0]         heap_base_q;
	logic [16:0]         block_bytes_q;
	logic [10:0]         total_blocks_q;
	ffba_pkg::heap_cfg_t cfg;
	logic [CW-1:0]       eff_total;
	logic                enable;

	logic                fj_valid, fj_ready;
	ffba_pkg::kind_t     fj_kind;
	logic [CW-1:0]       fj_val;
	logic                bj_valid, bj_ready;
	logic [QW-1:0]       bj_data;
	logic                front_ready;
	logic [1:0]          out_status;
	logic [31:0]         out_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q    <= 32'd0;
			block_bytes_q  <= 17'd64;
			total_blocks_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				ffba_pkg::REG_HEAP_BASE:    heap_base_q    <= cfg_data;
				ffba_pkg::REG_BLOCK_BYTES:  block_bytes_q  <= cfg_data[16:0];
				ffba_pkg::REG_TOTAL_BLOCKS: total_blocks_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign cfg.heap_base = heap_base_q;
	assign cfg.bb_eff    = (block_bytes_q == 17'd0) ? 17'd1 : block_bytes_q;
	assign eff_total     = (32'(total_blocks_q) > MAX_BLOCKS) ?
		CW'(MAX_BLOCKS) : CW'(total_blocks_q);
	assign s_tready      = front_ready;
	assign m_tdata       = {6'd0, out_addr, out_status};

	ffba_front #(.CW(CW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable),
		.cfg       (cfg),
		.eff_total (eff_total),
		.in_valid  (s_tvalid),
		.in_ready  (front_ready),
		.in_cmd    (s_tuser),
		.in_size   (s_tdata[31:0]),
		.in_addr   (s_tdata[63:32]),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job_kind  (fj_kind),
		.job_val   (fj_val)
	);

	ffba_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fj_valid),
		.in_ready  (fj_ready),
		.in_data   ({fj_kind, fj_val}),
		.out_valid (bj_valid),
		.out_ready (bj_ready),
		.out_data  (bj_data)
	);

	ffba_back #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW), .CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.eff_total  (eff_total),
		.init_done  (enable),
		.job_valid  (bj_valid),
		.job_ready  (bj_ready),
		.job_kind   (ffba_pkg::kind_t'(bj_data[QW-1:CW])),
		.job_val    (bj_data[CW-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_addr   (out_addr)
	);

endmodule
